/* rtl/hpid_pkg.sv */
package hpid_pkg;

    // angle constants, signed Q4.12
    localparam logic signed [16:0] PI_Q12     = 17'sd12868;
    localparam logic signed [16:0] TWO_PI_Q12 = 17'sd25736;

    // |drive| at or below this ends the turn
    localparam logic signed [16:0] DONE_LIMIT = 17'sd2;

    // magnitude of Kd * (e - previous e) fits in this many bits
    localparam int DIV_BITS = 33;

    localparam logic ACT_START  = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    localparam logic [15:0] GAIN_P_RESET      = 16'd256;
    localparam logic [15:0] GAIN_I_RESET      = 16'd0;
    localparam logic [15:0] GAIN_D_RESET      = 16'd0;
    localparam logic [14:0] MAX_VEL_RESET     = 15'd1024;
    localparam logic [14:0] ACCEL_LIMIT_RESET = 15'd128;
    localparam logic        ACCEL_EN_RESET    = 1'b1;
    localparam logic [9:0]  TIME_STEP_RESET   = 10'd32;

    typedef enum logic [2:0] {
        REG_GAIN_P      = 3'd0,
        REG_GAIN_I      = 3'd1,
        REG_GAIN_D      = 3'd2,
        REG_MAX_VEL     = 3'd3,
        REG_ACCEL_LIMIT = 3'd4,
        REG_ACCEL_EN    = 3'd5,
        REG_TIME_STEP   = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic               action;
        logic signed [15:0] target_heading_in;
        logic signed [15:0] start_velocity;
        logic signed [15:0] measured_yaw;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] left_drive;
        logic signed [15:0] right_drive;
        logic               done_res;
    } out_item_t;

    typedef struct packed {
        logic [15:0] gain_proportional;
        logic [15:0] gain_integral;
        logic [15:0] gain_derivative;
        logic [14:0] max_velocity;
        logic [14:0] accel_limit;
        logic        accel_limit_enable;
        logic [9:0]  time_step;
    } cfg_t;

    typedef struct packed {
        logic                  start;
        logic                  negate;
        logic [DIV_BITS-1:0]   dividend;
        logic [9:0]            divisor;
    } div_ctl_t;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic signed [DIV_BITS:0] quotient;
    } div_status_t;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } core_status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR,
        S_M_INT,
        S_M_P,
        S_M_D,
        S_M_I,
        S_ACC_I,
        S_DIV_WAIT,
        S_SCALE,
        S_SLEW,
        S_OUT
    } core_state_t;

endpackage

/* rtl/hpid_divider.sv */
module hpid_divider (
    input  logic                      clk,
    input  logic                      rst_n,
    input  hpid_pkg::div_ctl_t        ctl,
    output hpid_pkg::div_status_t     status
);

    localparam int CNT_W = $clog2(hpid_pkg::DIV_BITS + 1);

    logic [hpid_pkg::DIV_BITS-1:0] quo_reg;
    logic [9:0]                    rem_reg;
    logic [9:0]                    den_reg;
    logic                          neg_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic                          done_reg;

    logic [10:0] shifted;
    logic [10:0] trial;
    logic        fits;

    // restoring division, one quotient bit per cycle
    assign shifted = {rem_reg, quo_reg[hpid_pkg::DIV_BITS-1]};
    assign trial   = shifted - {1'b0, den_reg};
    assign fits    = (shifted >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CNT_W'(1));
            if (ctl.start)
                cnt_reg <= CNT_W'(hpid_pkg::DIV_BITS);
            else if (cnt_reg != '0)
                cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            quo_reg <= ctl.dividend;
            rem_reg <= '0;
            den_reg <= ctl.divisor;
            neg_reg <= ctl.negate;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= {quo_reg[hpid_pkg::DIV_BITS-2:0], fits};
            rem_reg <= fits ? trial[9:0] : shifted[9:0];
        end
    end

    always_comb
    begin
        status.busy     = (cnt_reg != '0);
        status.done     = done_reg;
        status.quotient = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
    end

endmodule

/* rtl/hpid_core.sv */
module hpid_core (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     take,
    input  hpid_pkg::in_item_t       item,
    input  hpid_pkg::cfg_t           cfg,
    input  logic                     res_ready,
    output hpid_pkg::core_status_t   status,
    output hpid_pkg::out_item_t      res
);

    hpid_pkg::core_state_t state_reg, state_next;

    logic                 active_reg,  active_next;
    logic signed [15:0]   target_reg,  target_next;
    logic signed [31:0]   integ_reg,   integ_next;
    logic signed [16:0]   perr_reg,    perr_next;
    logic signed [15:0]   pv_reg,      pv_next;

    logic signed [15:0]   yaw_reg,     yaw_next;
    logic signed [16:0]   e_reg,       e_next;
    logic signed [48:0]   prod_reg;
    logic signed [49:0]   acc_reg,     acc_next;
    logic signed [16:0]   v_reg,       v_next;
    hpid_pkg::out_item_t  res_reg,     res_next;

    // shared multiplier
    logic signed [16:0]   mul_a;
    logic signed [31:0]   mul_b;
    logic signed [48:0]   mul_p;
    logic                 mul_en;

    hpid_pkg::div_ctl_t    div_ctl;
    hpid_pkg::div_status_t div_st;

    logic [9:0]           ts_eff;
    logic signed [16:0]   d_raw;
    logic signed [16:0]   e_wrap;
    logic signed [17:0]   e_diff;
    logic signed [33:0]   integ_sum;
    logic signed [31:0]   integ_sat;
    logic signed [48:0]   prod_abs;
    logic signed [49:0]   acc_adj;
    logic signed [37:0]   v_trunc;
    logic signed [37:0]   v_max;
    logic signed [16:0]   v_clamp;
    logic signed [25:0]   lim;
    logic signed [25:0]   delta;
    logic signed [25:0]   delta_c;
    logic signed [25:0]   v_slew;
    logic signed [16:0]   v_fin;
    logic                 fin_done;

    hpid_divider u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (div_ctl),
        .status (div_st)
    );

    assign mul_p = mul_a * mul_b;

    // datapath terms
    always_comb
    begin
        ts_eff = (cfg.time_step == '0) ? 10'd1 : cfg.time_step;

        d_raw = $signed({target_reg[15], target_reg}) - $signed({yaw_reg[15], yaw_reg});
        if (d_raw > hpid_pkg::PI_Q12)
            e_wrap = d_raw - hpid_pkg::TWO_PI_Q12;
        else if (d_raw < -hpid_pkg::PI_Q12)
            e_wrap = d_raw + hpid_pkg::TWO_PI_Q12;
        else
            e_wrap = d_raw;

        e_diff = $signed({e_reg[16], e_reg}) - $signed({perr_reg[16], perr_reg});

        integ_sum = $signed({{2{integ_reg[31]}}, integ_reg}) + prod_reg[33:0];
        if (integ_sum[33:31] == 3'b000 || integ_sum[33:31] == 3'b111)
            integ_sat = integ_sum[31:0];
        else if (integ_sum[33])
            integ_sat = 32'sh8000_0000;
        else
            integ_sat = 32'sh7fff_ffff;

        prod_abs = prod_reg[48] ? -prod_reg : prod_reg;

        // truncate toward zero on the divide by 4096
        acc_adj = acc_reg + (acc_reg[49] ? 50'sd4095 : 50'sd0);
        v_trunc = acc_adj[49:12];
        v_max   = $signed({23'd0, cfg.max_velocity});
        if (v_trunc > v_max)
            v_clamp = v_max[16:0];
        else if (v_trunc < -v_max)
            v_clamp = -v_max[16:0];
        else
            v_clamp = v_trunc[16:0];

        // prod_reg holds accel_limit * ts here
        lim   = $signed({1'b0, prod_reg[24:0]});
        delta = $signed({{9{v_reg[16]}}, v_reg}) - $signed({{10{pv_reg[15]}}, pv_reg});
        if (delta > lim)
            delta_c = lim;
        else if (delta < -lim)
            delta_c = -lim;
        else
            delta_c = delta;
        v_slew = $signed({{10{pv_reg[15]}}, pv_reg}) + delta_c;
        v_fin  = cfg.accel_limit_enable ? v_slew[16:0] : v_reg;
        fin_done = (v_fin <= hpid_pkg::DONE_LIMIT) && (v_fin >= -hpid_pkg::DONE_LIMIT);
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        active_next = active_reg;
        target_next = target_reg;
        integ_next  = integ_reg;
        perr_next   = perr_reg;
        pv_next     = pv_reg;
        yaw_next    = yaw_reg;
        e_next      = e_reg;
        acc_next    = acc_reg;
        v_next      = v_reg;
        res_next    = res_reg;

        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;

        div_ctl.start    = 1'b0;
        div_ctl.negate   = prod_reg[48];
        div_ctl.dividend = prod_abs[hpid_pkg::DIV_BITS-1:0];
        div_ctl.divisor  = ts_eff;

        status.idle      = 1'b0;
        status.res_valid = 1'b0;

        case (state_reg)
            hpid_pkg::S_IDLE:
            begin
                status.idle = 1'b1;
                if (take)
                begin
                    if (item.action == hpid_pkg::ACT_START)
                    begin
                        target_next = item.target_heading_in;
                        pv_next     = item.start_velocity;
                        integ_next  = '0;
                        perr_next   = '0;
                        active_next = 1'b1;
                        res_next    = '{left_drive: '0, right_drive: '0, done_res: 1'b0};
                        state_next  = hpid_pkg::S_OUT;
                    end
                    else if (!active_reg)
                    begin
                        res_next   = '{left_drive: '0, right_drive: '0, done_res: 1'b1};
                        state_next = hpid_pkg::S_OUT;
                    end
                    else
                    begin
                        yaw_next   = item.measured_yaw;
                        state_next = hpid_pkg::S_ERR;
                    end
                end
            end

            hpid_pkg::S_ERR:
            begin
                e_next     = e_wrap;
                state_next = hpid_pkg::S_M_INT;
            end

            hpid_pkg::S_M_INT:
            begin
                mul_en     = 1'b1;
                mul_a      = e_reg;
                mul_b      = $signed({22'd0, ts_eff});
                state_next = hpid_pkg::S_M_P;
            end

            hpid_pkg::S_M_P:
            begin
                integ_next = integ_sat;
                mul_en     = 1'b1;
                mul_a      = $signed({1'b0, cfg.gain_proportional});
                mul_b      = $signed({{15{e_reg[16]}}, e_reg});
                state_next = hpid_pkg::S_M_D;
            end

            hpid_pkg::S_M_D:
            begin
                acc_next   = $signed({prod_reg[48], prod_reg});
                mul_en     = 1'b1;
                mul_a      = $signed({1'b0, cfg.gain_derivative});
                mul_b      = $signed({{14{e_diff[17]}}, e_diff});
                state_next = hpid_pkg::S_M_I;
            end

            hpid_pkg::S_M_I:
            begin
                div_ctl.start = 1'b1;
                mul_en        = 1'b1;
                mul_a         = $signed({1'b0, cfg.gain_integral});
                mul_b         = integ_reg;
                state_next    = hpid_pkg::S_ACC_I;
            end

            hpid_pkg::S_ACC_I:
            begin
                acc_next   = acc_reg + $signed({prod_reg[48], prod_reg});
                mul_en     = 1'b1;
                mul_a      = $signed({2'b00, cfg.accel_limit});
                mul_b      = $signed({22'd0, ts_eff});
                state_next = hpid_pkg::S_DIV_WAIT;
            end

            hpid_pkg::S_DIV_WAIT:
            begin
                if (div_st.done)
                begin
                    acc_next   = acc_reg
                               + $signed({{16{div_st.quotient[hpid_pkg::DIV_BITS]}},
                                          div_st.quotient});
                    state_next = hpid_pkg::S_SCALE;
                end
            end

            hpid_pkg::S_SCALE:
            begin
                v_next     = v_clamp;
                perr_next  = e_reg;
                state_next = hpid_pkg::S_SLEW;
            end

            hpid_pkg::S_SLEW:
            begin
                if (cfg.accel_limit_enable)
                    pv_next = v_fin[15:0];
                if (fin_done)
                begin
                    active_next = 1'b0;
                    res_next    = '{left_drive: '0, right_drive: '0, done_res: 1'b1};
                end
                else
                begin
                    // negating the most negative drive saturates
                    res_next.left_drive  = (v_fin[15:0] == 16'sh8000) ? 16'sh7fff
                                                                      : -v_fin[15:0];
                    res_next.right_drive = v_fin[15:0];
                    res_next.done_res    = 1'b0;
                end
                state_next = hpid_pkg::S_OUT;
            end

            hpid_pkg::S_OUT:
            begin
                status.res_valid = 1'b1;
                if (res_ready)
                    state_next = hpid_pkg::S_IDLE;
            end

            default:
            begin
                state_next = hpid_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= hpid_pkg::S_IDLE;
            active_reg <= 1'b0;
            target_reg <= '0;
            integ_reg  <= '0;
            perr_reg   <= '0;
            pv_reg     <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            active_reg <= active_next;
            target_reg <= target_next;
            integ_reg  <= integ_next;
            perr_reg   <= perr_next;
            pv_reg     <= pv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        yaw_reg <= yaw_next;
        e_reg   <= e_next;
        acc_reg <= acc_next;
        v_reg   <= v_next;
        res_reg <= res_next;
        if (mul_en)
            prod_reg <= mul_p;
    end

    assign res = res_reg;

endmodule

/* rtl/heading_pid_turn_controller_top.sv */
// Heading PID turn controller for a differential drive.
// Input channel (in_valid / in_stall / in_data): a request with action start
// loads the target heading and wheel velocity and arms the turn; a request
// with action sample carries a measured yaw and runs one PID step.
// Output channel (out_valid / out_stall / out_data): exactly one result per
// request, in order: left and right wheel commands and a done flag.
// Configuration: cfg_write with cfg_index and cfg_data writes one register;
// write only while no request is in progress.
// Flow: a start request, or a sample with no turn armed, goes from S_IDLE
// straight to S_OUT and its result moves from the core into the output register.
// An active sample passes the shared multiplier steps and the 33-step serial
// divider on the derivative term before its result is ready; the next request
// is taken only once the core is back in S_IDLE. in_stall is high from
// acceptance until the result moves into the output register, so the next
// request can be taken while that result still waits.
// When the receiver stalls, the result holds in the output register and a
// second finished result waits in the core until the first is taken.
// Reset clears the turn state, loads the register defaults and empties the
// output register.
module heading_pid_turn_controller_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  hpid_pkg::in_item_t    in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output hpid_pkg::out_item_t   out_data,
    input  logic                  cfg_write,
    input  logic [2:0]            cfg_index,
    input  logic [15:0]           cfg_data
);

    hpid_pkg::cfg_t          cfg_reg;
    hpid_pkg::core_status_t  core_st;
    hpid_pkg::out_item_t     core_res;
    hpid_pkg::out_item_t     out_data_reg;
    logic                    out_valid_reg;
    logic                    take;
    logic                    res_ready;

    assign in_stall  = !core_st.idle;
    assign take      = in_valid && !in_stall;
    assign res_ready = !out_valid_reg || !out_stall;

    hpid_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .item      (in_data),
        .cfg       (cfg_reg),
        .res_ready (res_ready),
        .status    (core_st),
        .res       (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_proportional  <= hpid_pkg::GAIN_P_RESET;
            cfg_reg.gain_integral      <= hpid_pkg::GAIN_I_RESET;
            cfg_reg.gain_derivative    <= hpid_pkg::GAIN_D_RESET;
            cfg_reg.max_velocity       <= hpid_pkg::MAX_VEL_RESET;
            cfg_reg.accel_limit        <= hpid_pkg::ACCEL_LIMIT_RESET;
            cfg_reg.accel_limit_enable <= hpid_pkg::ACCEL_EN_RESET;
            cfg_reg.time_step          <= hpid_pkg::TIME_STEP_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                hpid_pkg::REG_GAIN_P:      cfg_reg.gain_proportional  <= cfg_data;
                hpid_pkg::REG_GAIN_I:      cfg_reg.gain_integral      <= cfg_data;
                hpid_pkg::REG_GAIN_D:      cfg_reg.gain_derivative    <= cfg_data;
                hpid_pkg::REG_MAX_VEL:     cfg_reg.max_velocity       <= cfg_data[14:0];
                hpid_pkg::REG_ACCEL_LIMIT: cfg_reg.accel_limit        <= cfg_data[14:0];
                hpid_pkg::REG_ACCEL_EN:    cfg_reg.accel_limit_enable <= cfg_data[0];
                hpid_pkg::REG_TIME_STEP:   cfg_reg.time_step          <= cfg_data[9:0];
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_ready)
            out_valid_reg <= core_st.res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && core_st.res_valid)
            out_data_reg <= core_res;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // an accepted request keeps the core busy for at least the next cycle
    a_busy_after_take: assert property (
        @(posedge clk) disable iff (!rst_n)
        take |=> in_stall
    ) else $error("core ready again right after taking a request");

    // a finished turn always reports zero drive
    a_done_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.done_res) |->
            (out_data.left_drive == 16'sd0 && out_data.right_drive == 16'sd0)
    ) else $error("done result with nonzero drive");

    a_out_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data))
    ) else $error("stalled result changed");

endmodule
